FILE: rtl/stq_pkg.sv
// Shared types and constants for the sorted timer queue.
// No dependencies; stq_cell and sorted_timer_queue import this package.
`default_nettype none

package stq_pkg;

	// width of the running clock and of the stored due dates
	localparam int unsigned TIME_BITS = 64;

	// input opcodes
	localparam logic OP_SCHEDULE = 1'b0;
	localparam logic OP_ADVANCE  = 1'b1;

	// command broadcast from the controller to every cell of the queue
	typedef struct packed {
		logic insert; // place a new entry, shifting later entries towards the tail
		logic pop;    // drop the head, shifting every entry towards the head
	} stq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/stq_in_if.sv
// Input channel of the sorted timer queue: valid/ready plus the request payload.
// No dependencies.
`default_nettype none

interface stq_in_if #(
	parameter int unsigned HANDLE_BITS = 16,
	parameter int unsigned DELAY_BITS  = 40
);
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [DELAY_BITS-1:0]  amount;
	logic [HANDLE_BITS-1:0] call_handle;

	modport source (output valid, opcode, amount, call_handle, input ready);
	modport sink   (input valid, opcode, amount, call_handle, output ready);
endinterface

`default_nettype wire

FILE: rtl/stq_out_if.sv
// Result channel of the sorted timer queue: valid/ready plus the result payload.
// No dependencies.
`default_nettype none

interface stq_out_if #(
	parameter int unsigned HANDLE_BITS = 16,
	parameter int unsigned DELAY_BITS  = 40,
	parameter int unsigned COUNT_BITS  = 5
);
	logic                   valid;
	logic                   ready;
	logic                   fired_valid;
	logic [HANDLE_BITS-1:0] fired_handle;
	logic                   last;
	logic [DELAY_BITS-1:0]  next_delay;
	logic                   dropped;
	logic [COUNT_BITS-1:0]  pending_count;

	modport source (output valid, fired_valid, fired_handle, last, next_delay, dropped,
		pending_count, input ready);
	modport sink   (input valid, fired_valid, fired_handle, last, next_delay, dropped,
		pending_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/stq_cell.sv
// One slot of the sorted queue: a due date and a handle, shifted to and from its neighbours.
// Depends on stq_pkg for the command struct and the time width.
`default_nettype none

module stq_cell
	import stq_pkg::*;
#(
	parameter int unsigned HANDLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire stq_cmd_t               cmd,
	input  wire logic [TIME_BITS-1:0]   key,
	input  wire logic                   occ,
	input  wire logic [TIME_BITS-1:0]   left_due,
	input  wire logic [HANDLE_BITS-1:0] left_handle,
	input  wire logic                   left_le,
	input  wire logic [TIME_BITS-1:0]   right_due,
	input  wire logic [HANDLE_BITS-1:0] right_handle,
	input  wire logic [TIME_BITS-1:0]   new_due,
	input  wire logic [HANDLE_BITS-1:0] new_handle,
	output logic [TIME_BITS-1:0]        due,
	output logic [HANDLE_BITS-1:0]      handle,
	output logic                        le,
	output logic                        gt
);

	logic [TIME_BITS-1:0]   due_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// compare the held date against the broadcast key
	always_comb begin
		le = occ && (due_q <= key);
		gt = occ && (due_q > key);
	end

	assign due    = due_q;
	assign handle = handle_q;

	// hold, take the new entry, or take a neighbour's entry
	always_ff @(posedge clk) begin
		priority if (cmd.insert && !le) begin
			if (left_le) begin
				due_q    <= new_due;
				handle_q <= new_handle;
			end else begin
				due_q    <= left_due;
				handle_q <= left_handle;
			end
		end else if (cmd.pop) begin
			due_q    <= right_due;
			handle_q <= right_handle;
		end else begin
			due_q    <= due_q;
			handle_q <= handle_q;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_timer_queue.sv
// Sorted timer queue: a row of QUEUE_DEPTH cells ordered by due date, and its controller.
// Depends on stq_pkg, stq_in_if, stq_out_if and stq_cell.
//
// The block keeps a 64-bit clock and a queue of call handles sorted by due date, ties in
// arrival order. One request is taken at a time. Either kind of request has its first
// result registered through the steps sum, insert, scan, delay and result, in that order.
// An advance then registers one released handle per cycle while the result side takes
// them, and a request holds the input until its last result is registered; the next
// request is taken in the cycle after the last result is registered. The sequence follows
// from the single insert/pop shift of the cell row and the scan that finds the first entry
// due later than now. The result register lets the next request in while the last result
// still waits to be taken.
`default_nettype none

module sorted_timer_queue
	import stq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned HANDLE_BITS = 16,
	parameter int unsigned DELAY_BITS  = 40
) (
	input wire logic   clk,
	input wire logic   arst_n,
	stq_in_if.sink     in_ch,
	stq_out_if.source  out_ch
);

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORK,
		ST_SCAN,
		ST_FIN,
		ST_EMIT
	} state_t;

	state_t                 state_q;
	logic                   op_q;
	logic [TIME_BITS-1:0]   now_q;
	logic [TIME_BITS-1:0]   at_q;
	logic [HANDLE_BITS-1:0] hdl_q;
	logic [CW-1:0]          count_q;
	logic [CW-1:0]          k_q;
	logic                   drop_q;
	logic [TIME_BITS-1:0]   sel_due_s1;
	logic                   sel_any_s1;
	logic [DELAY_BITS-1:0]  nd_q;
	logic [CW-1:0]          pend_q;

	logic                   ov_q;
	logic                   o_fv_q;
	logic [HANDLE_BITS-1:0] o_fh_q;
	logic                   o_last_q;
	logic [DELAY_BITS-1:0]  o_nd_q;
	logic                   o_drop_q;
	logic [CW-1:0]          o_pend_q;

	logic                   in_xfer;
	logic                   out_free;
	logic                   full;
	logic                   do_pop;
	stq_cmd_t               cmd;
	logic [TIME_BITS-1:0]   key;
	logic [TIME_BITS-1:0]   amount_ext;
	logic [TIME_BITS-1:0]   sum;
	logic [TIME_BITS-1:0]   diff;
	logic [CW-1:0]          le_cnt;
	logic [TIME_BITS-1:0]   first_due;
	logic                   any_gt;

	logic [TIME_BITS-1:0]   due_w  [QUEUE_DEPTH];
	logic [HANDLE_BITS-1:0] hdl_w  [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] le_w;
	logic [QUEUE_DEPTH-1:0] gt_w;
	logic [QUEUE_DEPTH-1:0] first_w;

	// handshake and broadcast controls
	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign out_free    = !ov_q || out_ch.ready;
	assign full        = (count_q == CW'(QUEUE_DEPTH));
	assign do_pop      = (state_q == ST_EMIT) && out_free && (op_q == OP_ADVANCE)
		&& (k_q != '0);
	assign cmd.insert  = (state_q == ST_WORK) && (op_q == OP_SCHEDULE) && !full;
	assign cmd.pop     = do_pop;
	assign key         = (state_q == ST_WORK) ? at_q : now_q;
	assign amount_ext  = {{(TIME_BITS - DELAY_BITS){1'b0}}, in_ch.amount};
	assign sum         = now_q + amount_ext;
	assign diff        = sel_due_s1 - now_q;

	// row of cells, each fed by its neighbours
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic [TIME_BITS-1:0]   l_due;
		logic [HANDLE_BITS-1:0] l_hdl;
		logic                   l_le;
		logic [TIME_BITS-1:0]   r_due;
		logic [HANDLE_BITS-1:0] r_hdl;

		if (i == 0) begin : g_head
			assign l_due = at_q;
			assign l_hdl = hdl_q;
			assign l_le  = 1'b1;
			assign first_w[i] = gt_w[i];
		end else begin : g_body
			assign l_due = due_w[i-1];
			assign l_hdl = hdl_w[i-1];
			assign l_le  = le_w[i-1];
			assign first_w[i] = gt_w[i] && le_w[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign r_due = due_w[i];
			assign r_hdl = hdl_w[i];
		end else begin : g_inner
			assign r_due = due_w[i+1];
			assign r_hdl = hdl_w[i+1];
		end

		stq_cell #(
			.HANDLE_BITS(HANDLE_BITS)
		) u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.key         (key),
			.occ         (CW'(i) < count_q),
			.left_due    (l_due),
			.left_handle (l_hdl),
			.left_le     (l_le),
			.right_due   (r_due),
			.right_handle(r_hdl),
			.new_due     (at_q),
			.new_handle  (hdl_q),
			.due         (due_w[i]),
			.handle      (hdl_w[i]),
			.le          (le_w[i]),
			.gt          (gt_w[i])
		);
	end

	// count the due entries and pick the first entry due later than now
	always_comb begin
		le_cnt    = '0;
		first_due = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			le_cnt    = le_cnt + CW'(le_w[i]);
			first_due = first_due | (first_w[i] ? due_w[i] : '0);
		end
		any_gt = |gt_w;
	end

	// sequence one request: control state, clock, queue count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			now_q   <= '0;
			count_q <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						if (in_ch.opcode == OP_ADVANCE) begin
							now_q <= sum;
						end
						state_q <= ST_WORK;
					end
				end
				ST_WORK: begin
					if (cmd.insert) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						ov_q <= 1'b1;
						if (do_pop) begin
							count_q <= count_q - CW'(1);
						end
						if (!do_pop || k_q == CW'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			op_q  <= in_ch.opcode;
			at_q  <= sum;
			hdl_q <= in_ch.call_handle;
		end
		if (state_q == ST_WORK) begin
			drop_q <= (op_q == OP_SCHEDULE) && full;
		end
		if (state_q == ST_SCAN) begin
			k_q        <= le_cnt;
			sel_due_s1 <= first_due;
			sel_any_s1 <= any_gt;
		end
		if (state_q == ST_FIN) begin
			// saturate the delay to the field width, zero when no entry is due later
			if (!sel_any_s1) begin
				nd_q <= '0;
			end else if (|diff[TIME_BITS-1:DELAY_BITS]) begin
				nd_q <= '1;
			end else begin
				nd_q <= diff[DELAY_BITS-1:0];
			end
			pend_q <= (op_q == OP_ADVANCE) ? (count_q - k_q) : count_q;
		end
		if (do_pop) begin
			k_q <= k_q - CW'(1);
		end
		if (state_q == ST_EMIT && out_free) begin
			o_nd_q   <= nd_q;
			o_pend_q <= pend_q;
			o_drop_q <= drop_q;
			if (do_pop) begin
				o_fv_q   <= 1'b1;
				o_fh_q   <= hdl_w[0];
				o_last_q <= (k_q == CW'(1));
			end else begin
				o_fv_q   <= 1'b0;
				o_fh_q   <= '0;
				o_last_q <= 1'b1;
			end
		end
	end

	assign out_ch.valid         = ov_q;
	assign out_ch.fired_valid   = o_fv_q;
	assign out_ch.fired_handle  = o_fh_q;
	assign out_ch.last          = o_last_q;
	assign out_ch.next_delay    = o_nd_q;
	assign out_ch.dropped       = o_drop_q;
	assign out_ch.pending_count = o_pend_q;

endmodule

`default_nettype wire

FILE: rtl/stq_check.sv
// Port-level checks for the sorted timer queue, bound to the top level.
// Depends on the port behaviour of sorted_timer_queue only.
`default_nettype none

module stq_check #(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned HANDLE_BITS = 16,
	parameter int unsigned COUNT_BITS  = 5
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic                   fired_valid,
	input wire logic [HANDLE_BITS-1:0] fired_handle,
	input wire logic                   last,
	input wire logic                   dropped,
	input wire logic [COUNT_BITS-1:0]  pending_count
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fired_handle) && $stable(last))
		else $error("stalled result changed");

	// take no request in the cycle after a transfer
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while another is in progress");

	// an empty result closes its request and names no call
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !fired_valid |-> last && (fired_handle == '0))
		else $error("empty result not final or carries a handle");

	// drop only when full, and never on a released call
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped |-> !fired_valid && (pending_count == COUNT_BITS'(QUEUE_DEPTH)))
		else $error("drop reported without a full queue");

endmodule

bind sorted_timer_queue stq_check #(
	.QUEUE_DEPTH(QUEUE_DEPTH),
	.HANDLE_BITS(HANDLE_BITS),
	.COUNT_BITS ($clog2(QUEUE_DEPTH + 1))
) u_stq_check (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.fired_valid  (out_ch.fired_valid),
	.fired_handle (out_ch.fired_handle),
	.last         (out_ch.last),
	.dropped      (out_ch.dropped),
	.pending_count(out_ch.pending_count)
);

`default_nettype wire
